>>> rtl/roc_pkg.sv
// Shared types, register codes and constants for the ring oscillator register block.
`default_nettype none

package roc_pkg;

    // Oscillator nominal frequency and field widths.
    localparam int NOMINAL_HZ = 6500000;
    localparam int HZ_W       = 23;
    localparam int OFF_W      = 12;
    localparam int ADDR_W     = 14;
    localparam int DATA_W     = 32;
    localparam int SEED_W     = 64;
    localparam int PADDR_W    = 4;

    // Item opcodes.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Atomic alias codes taken from address bits 13:12.
    localparam logic [1:0] AL_NORMAL = 2'd0;
    localparam logic [1:0] AL_XOR    = 2'd1;
    localparam logic [1:0] AL_SET    = 2'd2;
    localparam logic [1:0] AL_CLR    = 2'd3;

    // Register offsets.
    localparam logic [OFF_W-1:0] OFF_CTRL    = 12'h000;
    localparam logic [OFF_W-1:0] OFF_FREQA   = 12'h004;
    localparam logic [OFF_W-1:0] OFF_FREQB   = 12'h008;
    localparam logic [OFF_W-1:0] OFF_DORMANT = 12'h00c;
    localparam logic [OFF_W-1:0] OFF_DIV     = 12'h010;
    localparam logic [OFF_W-1:0] OFF_PHASE   = 12'h014;
    localparam logic [OFF_W-1:0] OFF_STATUS  = 12'h018;
    localparam logic [OFF_W-1:0] OFF_RANDOM  = 12'h01c;
    localparam logic [OFF_W-1:0] OFF_COUNT   = 12'h020;

    // Passwords and codes.
    localparam logic [11:0] EN_DISABLE   = 12'hd1e;
    localparam logic [11:0] EN_ENABLE    = 12'hfab;
    localparam logic [11:0] RANGE_LOW    = 12'hfa4;
    localparam logic [11:0] RANGE_HIGH   = 12'hfa7;
    localparam logic [31:0] DORMANT_CODE = 32'h636f6d61;
    localparam logic [31:0] WAKE_CODE    = 32'h77616b65;
    localparam logic [15:0] FREQ_PASS    = 16'h9696;
    localparam logic [31:0] FREQ_MASK    = 32'h96967777;
    localparam logic [11:0] DIV_PASS     = 12'haa0;
    localparam logic [11:0] DIV_BAD      = 12'habf;
    localparam logic [11:0] DIV_RESET    = 12'hab0;
    localparam logic [11:0] PHASE_RESET  = 12'haa8;
    localparam logic [7:0]  PHASE_PASS   = 8'haa;
    localparam logic [63:0] GOLDEN       = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] PRNG_MULT    = 64'h2545f4914f6cdd1d;

    // Output frequency for divisors 1 to 32, indexed by divisor minus one.
    localparam logic [HZ_W-1:0] HZ_TABLE [32] = '{
        HZ_W'(NOMINAL_HZ / 1),  HZ_W'(NOMINAL_HZ / 2),  HZ_W'(NOMINAL_HZ / 3),
        HZ_W'(NOMINAL_HZ / 4),  HZ_W'(NOMINAL_HZ / 5),  HZ_W'(NOMINAL_HZ / 6),
        HZ_W'(NOMINAL_HZ / 7),  HZ_W'(NOMINAL_HZ / 8),  HZ_W'(NOMINAL_HZ / 9),
        HZ_W'(NOMINAL_HZ / 10), HZ_W'(NOMINAL_HZ / 11), HZ_W'(NOMINAL_HZ / 12),
        HZ_W'(NOMINAL_HZ / 13), HZ_W'(NOMINAL_HZ / 14), HZ_W'(NOMINAL_HZ / 15),
        HZ_W'(NOMINAL_HZ / 16), HZ_W'(NOMINAL_HZ / 17), HZ_W'(NOMINAL_HZ / 18),
        HZ_W'(NOMINAL_HZ / 19), HZ_W'(NOMINAL_HZ / 20), HZ_W'(NOMINAL_HZ / 21),
        HZ_W'(NOMINAL_HZ / 22), HZ_W'(NOMINAL_HZ / 23), HZ_W'(NOMINAL_HZ / 24),
        HZ_W'(NOMINAL_HZ / 25), HZ_W'(NOMINAL_HZ / 26), HZ_W'(NOMINAL_HZ / 27),
        HZ_W'(NOMINAL_HZ / 28), HZ_W'(NOMINAL_HZ / 29), HZ_W'(NOMINAL_HZ / 30),
        HZ_W'(NOMINAL_HZ / 31), HZ_W'(NOMINAL_HZ / 32)
    };

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_DONE
    } t_roc_state;

    // Combine an old register value with write data through an alias.
    function automatic logic [31:0] alias_combine(input logic [31:0] old_val,
                                                  input logic [31:0] wdata,
                                                  input logic [1:0]  alias_sel);
        logic [31:0] res;
        case (alias_sel)
            AL_XOR:  res = old_val ^ wdata;
            AL_SET:  res = old_val | wdata;
            AL_CLR:  res = old_val & ~wdata;
            default: res = wdata;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/roc_if.sv
// Request and response channel interfaces of the ring oscillator register block.
`default_nettype none

interface roc_req_if;
    import roc_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output opcode, output address, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input address, input write_data,
                    output ready);
endinterface

interface roc_rsp_if;
    import roc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic [HZ_W-1:0]   clock_hz;

    modport source (output valid, output read_data, output clock_hz, input ready);
    modport sink   (input valid, input read_data, input clock_hz, output ready);
endinterface

`default_nettype wire

>>> rtl/ring_oscillator_control_registers_top.sv
// Ring oscillator register block: bus reads, password-checked writes, ticks and PRNG.
//
// Usage: requests arrive on i_req (opcode, address, write_data) with a
// valid/ready handshake; each request yields exactly one response on o_rsp
// (read_data, clock_hz). The APB port writes the 64-bit generator seed at
// any address with bit 3 clear, which also reloads the generator state; the
// user must write it only while the block is idle, as the block does not enforce it.
// Sequence: a read, write or tick passes through the execute and done
// states; its response is loaded into the output register as the block
// returns to idle, where it accepts the next request. The random bit, read
// while the oscillator runs, adds three multiply states: the low 64 bits
// of the xorshift product come from three 32x32 partial products on one
// shared multiplier. The response sits in an output register, so the next
// request may be accepted while the receiver stalls; the block holds in its
// final step only if that register is still full.
// Reset (synchronous, active low) loads the documented register values,
// clears the seed and sets the generator state to the golden-ratio constant.
`default_nettype none

module ring_oscillator_control_registers_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    roc_req_if.sink          i_req,
    roc_rsp_if.source        o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [roc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [roc_pkg::SEED_W-1:0]  pwdata,
    output logic [roc_pkg::SEED_W-1:0]       prdata,
    output logic             pready
);
    import roc_pkg::*;

    // Sequencer state.
    t_roc_state r_state, n_state;

    // Captured request.
    logic [1:0]        r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_wdata;

    // Architectural registers.
    logic [23:0]       r_ctrl, n_ctrl;
    logic [31:0]       r_freqa, n_freqa;
    logic [31:0]       r_freqb, n_freqb;
    logic              r_dormant, n_dormant;
    logic [11:0]       r_div, n_div;
    logic [11:0]       r_phase, n_phase;
    logic [7:0]        r_count, n_count;
    logic [63:0]       r_prng, n_prng;
    logic              r_bad, n_bad;
    logic [SEED_W-1:0] r_seed;

    // Working registers of the item in flight.
    logic [31:0]       r_rdata, n_rdata;
    logic              r_rng, n_rng;
    logic [63:0]       r_acc, n_acc;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic [31:0]       r_out_rdata, n_out_rdata;
    logic [HZ_W-1:0]   r_out_hz, n_out_hz;

    // Decoded fields and derived status.
    logic [OFF_W-1:0]  off;
    logic [1:0]        alias_sel;
    logic              enabled;
    logic              running;
    logic [31:0]       status_word;
    logic [11:0]       div_diff;
    logic [4:0]        hz_idx;
    logic [HZ_W-1:0]   hz_now;
    logic              cfg_wr;
    logic              out_free;

    // Shared multiplier.
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;

    // Handshake controls from the output decoder.
    logic              req_ready;
    logic              exec_en;
    logic              done_en;

    assign off       = r_addr[OFF_W-1:0];
    assign alias_sel = r_addr[ADDR_W-1:OFF_W];
    assign enabled   = (r_ctrl[23:12] != EN_DISABLE);
    assign running   = enabled && !r_dormant;
    assign cfg_wr    = psel && penable && pwrite && pready && !paddr[PADDR_W-1];
    assign out_free  = !r_out_valid || o_rsp.ready;

    // Status word assembled from the enable, dormant and badwrite state.
    always_comb begin
        status_word = '0;
        if (enabled) begin
            status_word[12] = 1'b1;
            if (!r_dormant) begin
                status_word[31] = 1'b1;
                status_word[16] = 1'b1;
            end
        end
        status_word[24] = r_bad;
    end

    // Divisor decode: zero difference means 32, out of range means 31.
    always_comb begin
        div_diff = r_div - DIV_PASS;
        if (r_div < DIV_PASS) begin
            hz_idx = 5'd30;
        end else if (div_diff == 12'd0) begin
            hz_idx = 5'd31;
        end else if (div_diff > 12'd31) begin
            hz_idx = 5'd30;
        end else begin
            hz_idx = div_diff[4:0] - 5'd1;
        end
        hz_now = running ? HZ_TABLE[hz_idx] : '0;
    end

    // Operand selection for the three partial products of the generator output.
    always_comb begin
        mul_a = (r_state == ST_MUL1) ? r_prng[63:32] : r_prng[31:0];
        mul_b = (r_state == ST_MUL2) ? PRNG_MULT[63:32] : PRNG_MULT[31:0];
        mul_p = mul_a * mul_b;
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_op == OP_READ && off == OFF_RANDOM && running) begin
                    n_state = ST_MUL0;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MUL0: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output decoding of the sequencer.
    always_comb begin
        req_ready = 1'b0;
        exec_en   = 1'b0;
        done_en   = 1'b0;
        unique case (r_state)
            ST_IDLE: req_ready = 1'b1;
            ST_EXEC: exec_en   = 1'b1;
            ST_DONE: done_en   = out_free;
            default: ;
        endcase
    end

    // Register updates for reads, writes, ticks, the generator and the output.
    always_comb begin
        logic [31:0] comb_v;
        logic [11:0] en_f;
        logic [11:0] rg_f;
        logic [63:0] xs;

        n_ctrl      = r_ctrl;
        n_freqa     = r_freqa;
        n_freqb     = r_freqb;
        n_dormant   = r_dormant;
        n_div       = r_div;
        n_phase     = r_phase;
        n_count     = r_count;
        n_prng      = r_prng;
        n_bad       = r_bad;
        n_rdata     = r_rdata;
        n_rng       = r_rng;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_rdata = r_out_rdata;
        n_out_hz    = r_out_hz;
        comb_v      = '0;
        en_f        = '0;
        rg_f        = '0;
        xs          = r_prng;

        if (exec_en) begin
            n_rdata = '0;
            n_rng   = 1'b0;
            if (r_op == OP_READ) begin
                unique case (off)
                    OFF_CTRL:    n_rdata = {8'd0, r_ctrl};
                    OFF_FREQA:   n_rdata = r_freqa;
                    OFF_FREQB:   n_rdata = r_freqb;
                    OFF_DORMANT: n_rdata = r_dormant ? DORMANT_CODE : WAKE_CODE;
                    OFF_DIV:     n_rdata = {20'd0, r_div};
                    OFF_PHASE:   n_rdata = {20'd0, r_phase};
                    OFF_STATUS:  n_rdata = status_word;
                    OFF_RANDOM: begin
                        // Step the xorshift state; the multiply follows.
                        if (running) begin
                            xs     = r_prng ^ (r_prng >> 12);
                            xs     = xs ^ (xs << 25);
                            xs     = xs ^ (xs >> 27);
                            n_prng = xs;
                            n_rng  = 1'b1;
                        end
                    end
                    OFF_COUNT:   n_rdata = {24'd0, r_count};
                    default:     n_rdata = '0;
                endcase
            end else if (r_op == OP_WRITE) begin
                unique case (off)
                    OFF_CTRL: begin
                        comb_v = alias_combine({8'd0, r_ctrl}, r_wdata, alias_sel);
                        en_f   = comb_v[23:12];
                        rg_f   = comb_v[11:0];
                        if (en_f != EN_DISABLE && en_f != EN_ENABLE) begin
                            n_bad = 1'b1;
                            en_f  = EN_ENABLE;
                        end
                        if (rg_f < RANGE_LOW || rg_f > RANGE_HIGH) begin
                            n_bad = 1'b1;
                            rg_f  = RANGE_LOW;
                        end
                        n_ctrl = {en_f, rg_f};
                    end
                    OFF_FREQA: begin
                        comb_v = alias_combine(r_freqa, r_wdata, alias_sel);
                        if (comb_v[31:16] != FREQ_PASS) begin
                            n_bad   = 1'b1;
                            n_freqa = '0;
                        end else begin
                            n_freqa = comb_v & FREQ_MASK;
                        end
                    end
                    OFF_FREQB: begin
                        comb_v = alias_combine(r_freqb, r_wdata, alias_sel);
                        if (comb_v[31:16] != FREQ_PASS) begin
                            n_bad   = 1'b1;
                            n_freqb = '0;
                        end else begin
                            n_freqb = comb_v & FREQ_MASK;
                        end
                    end
                    OFF_DORMANT: begin
                        n_dormant = (r_wdata == DORMANT_CODE);
                        if (r_wdata != DORMANT_CODE && r_wdata != WAKE_CODE) begin
                            n_bad = 1'b1;
                        end
                    end
                    OFF_DIV: begin
                        comb_v = alias_combine({20'd0, r_div}, r_wdata, alias_sel);
                        if (comb_v[11:0] < DIV_PASS) begin
                            n_bad = 1'b1;
                            n_div = DIV_BAD;
                        end else begin
                            n_div = comb_v[11:0];
                        end
                    end
                    OFF_PHASE: begin
                        comb_v = alias_combine({20'd0, r_phase}, r_wdata, alias_sel);
                        if (comb_v[11:4] != PHASE_PASS) begin
                            n_bad   = 1'b1;
                            n_phase = '0;
                        end else begin
                            n_phase = comb_v[11:0];
                        end
                    end
                    OFF_STATUS: begin
                        if (r_wdata[24]) begin
                            n_bad = 1'b0;
                        end
                    end
                    OFF_COUNT:   n_count = r_wdata[7:0];
                    default: ;
                endcase
            end else if (r_op == OP_TICK) begin
                if (running && r_count != 8'd0) begin
                    n_count = r_count - 8'd1;
                end
            end
        end

        // Low 64 bits of state times multiplier from three partial products.
        if (r_state == ST_MUL0) begin
            n_acc = mul_p;
        end else if (r_state == ST_MUL1 || r_state == ST_MUL2) begin
            n_acc = {r_acc[63:32] + mul_p[31:0], r_acc[31:0]};
        end

        // Load the response once the output register has room.
        if (done_en) begin
            n_out_valid = 1'b1;
            n_out_rdata = r_rng ? {31'd0, r_acc[63]} : r_rdata;
            n_out_hz    = hz_now;
        end

        // Seed write from the configuration port reloads the generator.
        if (cfg_wr) begin
            n_prng = (pwdata != '0) ? pwdata : GOLDEN;
        end
    end

    // Control and architectural state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ctrl      <= {EN_ENABLE, RANGE_LOW};
            r_freqa     <= '0;
            r_freqb     <= '0;
            r_dormant   <= 1'b0;
            r_div       <= DIV_RESET;
            r_phase     <= PHASE_RESET;
            r_count     <= '0;
            r_prng      <= GOLDEN;
            r_bad       <= 1'b0;
            r_seed      <= '0;
            r_out_valid <= 1'b0;
            r_rng       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ctrl      <= n_ctrl;
            r_freqa     <= n_freqa;
            r_freqb     <= n_freqb;
            r_dormant   <= n_dormant;
            r_div       <= n_div;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_prng      <= n_prng;
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
            r_rng       <= n_rng;
            if (cfg_wr) begin
                r_seed <= pwdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && req_ready) begin
            r_op    <= i_req.opcode;
            r_addr  <= i_req.address;
            r_wdata <= i_req.write_data;
        end
        r_rdata     <= n_rdata;
        r_acc       <= n_acc;
        r_out_rdata <= n_out_rdata;
        r_out_hz    <= n_out_hz;
    end

    // Port drive.
    assign i_req.ready     = req_ready;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out_rdata;
    assign o_rsp.clock_hz  = r_out_hz;
    assign pready          = 1'b1;
    assign prdata          = paddr[PADDR_W-1] ? '0 : r_seed;

    // An accepted request is executed in the following cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_state == ST_EXEC)
        else $error("accepted request did not enter execution");

    // The partial products run in a fixed order.
    a_mul_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MUL0 |=> r_state == ST_MUL1 ##1 r_state == ST_MUL2)
        else $error("multiply sequence broken");

    // A tick never raises the count.
    a_tick_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EXEC && r_op == OP_TICK |=> r_count <= $past(r_count))
        else $error("tick increased the count");

    // The divider register always holds a passing code.
    a_div_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div >= DIV_PASS)
        else $error("divider register below its password");

    // The enable field always holds one of its two codes.
    a_ctrl_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl[23:12] == EN_DISABLE || r_ctrl[23:12] == EN_ENABLE)
        else $error("control enable field holds an illegal code");

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the ring oscillator register block.
`timescale 1ns / 100ps

module testbench;
    import roc_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_PER_PASS = 550;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 12;

    typedef struct {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_osc_req;

    typedef struct {
        logic [DATA_W-1:0] rd;
        logic [HZ_W-1:0]   hz;
    } t_osc_rsp;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Configuration port.
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [SEED_W-1:0]   pwdata;
    logic [SEED_W-1:0]   prdata;
    logic                pready;

    roc_req_if req_ch ();
    roc_rsp_if rsp_ch ();

    ring_oscillator_control_registers_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Requests waiting to be driven and responses waiting to arrive.
    t_osc_req req_backlog [$];
    t_osc_rsp pending_rsps [$];

    int unsigned req_idle_pct    = 0;
    int unsigned rsp_idle_pct    = 0;
    logic        long_hold_armed = 1'b0;
    int          long_hold_count = 0;
    int          fail_count      = 0;
    int          cycle_count     = 0;

    // Predicted register state of the block.
    logic [23:0] ctrl_reg;
    logic [31:0] freqa_reg;
    logic [31:0] freqb_reg;
    logic        dormant;
    logic [11:0] div_reg;
    logic [11:0] phase_reg;
    logic [7:0]  count_reg;
    logic [63:0] rng_state;
    logic        badwrite;

    task automatic reset_regs();
        ctrl_reg  = {EN_ENABLE, RANGE_LOW};
        freqa_reg = '0;
        freqb_reg = '0;
        dormant   = 1'b0;
        div_reg   = DIV_RESET;
        phase_reg = PHASE_RESET;
        count_reg = '0;
        rng_state = GOLDEN;
        badwrite  = 1'b0;
    endtask

    function automatic logic osc_enabled();
        return ctrl_reg[23:12] != EN_DISABLE;
    endfunction

    function automatic logic osc_running();
        return osc_enabled() && !dormant;
    endfunction

    // Divisor from the DIV register: zero means 32 and anything past 31 clamps.
    function automatic int osc_divisor();
        logic [11:0] d;
        if (div_reg < DIV_PASS) return 31;
        d = div_reg - DIV_PASS;
        if (d == 12'd0) return 32;
        if (d > 12'd31) return 31;
        return int'(d);
    endfunction

    function automatic logic [HZ_W-1:0] osc_hz();
        if (!osc_running()) return '0;
        return HZ_W'(NOMINAL_HZ / osc_divisor());
    endfunction

    function automatic logic [31:0] merge_alias(input logic [31:0] old_val,
                                                input logic [31:0] wdata,
                                                input logic [1:0]  al);
        case (al)
            AL_XOR:  return old_val ^ wdata;
            AL_SET:  return old_val | wdata;
            AL_CLR:  return old_val & ~wdata;
            default: return wdata;
        endcase
    endfunction

    function automatic logic [31:0] status_value();
        logic [31:0] v;
        v = '0;
        if (osc_enabled()) begin
            v[12] = 1'b1;
            if (!dormant) begin
                v[31] = 1'b1;
                v[16] = 1'b1;
            end
        end
        v[24] = badwrite;
        return v;
    endfunction

    // Apply one request to the predicted state and work out its response.
    task automatic reg_block_step(input t_osc_req rq, output t_osc_rsp rs);
        logic [11:0] off;
        logic [1:0]  al;
        logic [31:0] v;
        logic [31:0] rd;
        logic [11:0] en;
        logic [11:0] rg;
        logic [63:0] x;
        logic [63:0] prod;
        off = rq.addr[11:0];
        al  = rq.addr[13:12];
        rd  = '0;
        case (rq.op)
            OP_READ: begin
                case (off)
                    OFF_CTRL:    rd = {8'h00, ctrl_reg};
                    OFF_FREQA:   rd = freqa_reg;
                    OFF_FREQB:   rd = freqb_reg;
                    OFF_DORMANT: rd = dormant ? DORMANT_CODE : WAKE_CODE;
                    OFF_DIV:     rd = {20'h0, div_reg};
                    OFF_PHASE:   rd = {20'h0, phase_reg};
                    OFF_STATUS:  rd = status_value();
                    OFF_RANDOM: begin
                        // The generator only steps while the oscillator runs.
                        if (osc_running()) begin
                            x = rng_state;
                            x = x ^ (x >> 12);
                            x = x ^ (x << 25);
                            x = x ^ (x >> 27);
                            rng_state = x;
                            prod = x * PRNG_MULT;
                            rd = {31'h0, prod[63]};
                        end
                    end
                    OFF_COUNT:   rd = {24'h0, count_reg};
                    default:     rd = '0;
                endcase
            end
            OP_WRITE: begin
                case (off)
                    OFF_CTRL: begin
                        v  = merge_alias({8'h00, ctrl_reg}, rq.data, al);
                        en = v[23:12];
                        rg = v[11:0];
                        if (en != EN_DISABLE && en != EN_ENABLE) begin
                            badwrite = 1'b1;
                            en = EN_ENABLE;
                        end
                        if (rg < RANGE_LOW || rg > RANGE_HIGH) begin
                            badwrite = 1'b1;
                            rg = RANGE_LOW;
                        end
                        ctrl_reg = {en, rg};
                    end
                    OFF_FREQA: begin
                        v = merge_alias(freqa_reg, rq.data, al);
                        if (v[31:16] != FREQ_PASS) begin
                            badwrite  = 1'b1;
                            freqa_reg = '0;
                        end else begin
                            freqa_reg = v & FREQ_MASK;
                        end
                    end
                    OFF_FREQB: begin
                        v = merge_alias(freqb_reg, rq.data, al);
                        if (v[31:16] != FREQ_PASS) begin
                            badwrite  = 1'b1;
                            freqb_reg = '0;
                        end else begin
                            freqb_reg = v & FREQ_MASK;
                        end
                    end
                    OFF_DORMANT: begin
                        // Aliases do not apply here; any non-sleep value wakes.
                        dormant = (rq.data == DORMANT_CODE);
                        if (rq.data != DORMANT_CODE && rq.data != WAKE_CODE) badwrite = 1'b1;
                    end
                    OFF_DIV: begin
                        v = merge_alias({20'h0, div_reg}, rq.data, al);
                        if (v[11:0] < DIV_PASS) begin
                            badwrite = 1'b1;
                            div_reg  = DIV_BAD;
                        end else begin
                            div_reg = v[11:0];
                        end
                    end
                    OFF_PHASE: begin
                        v = merge_alias({20'h0, phase_reg}, rq.data, al);
                        if (v[11:4] != PHASE_PASS) begin
                            badwrite  = 1'b1;
                            phase_reg = '0;
                        end else begin
                            phase_reg = v[11:0];
                        end
                    end
                    OFF_STATUS: begin
                        if (rq.data[24]) badwrite = 1'b0;
                    end
                    OFF_COUNT: count_reg = rq.data[7:0];
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (osc_running() && count_reg != 8'd0) count_reg = count_reg - 8'd1;
            end
            default: ;
        endcase
        rs.rd = rd;
        rs.hz = osc_hz();
    endtask

    // Random request, mostly with content that passes the password checks.
    function automatic t_osc_req random_req();
        t_osc_req    r;
        int unsigned pick;
        int unsigned sel;
        logic [11:0] off;
        pick   = $urandom_range(99);
        sel    = $urandom_range(9);
        r.data = $urandom();
        off    = (sel == 9) ? 12'($urandom()) : 12'(sel * 4);
        if (pick < 30) r.op = OP_TICK;
        else if (pick < 62) r.op = OP_READ;
        else if (pick < 97) r.op = OP_WRITE;
        else r.op = 2'd3;
        if (r.op == OP_READ && $urandom_range(2) == 0) off = OFF_RANDOM;
        r.addr = {($urandom_range(3) == 0) ? 2'($urandom()) : AL_NORMAL, off};
        if (r.op == OP_WRITE && $urandom_range(9) < 8) begin
            case (off)
                OFF_CTRL: r.data = {8'($urandom()),
                                    ($urandom_range(4) == 0) ? EN_DISABLE : EN_ENABLE,
                                    RANGE_LOW + 12'($urandom_range(3))};
                OFF_FREQA, OFF_FREQB: r.data = {FREQ_PASS, 16'($urandom())};
                OFF_DORMANT: r.data = ($urandom_range(3) == 0) ? DORMANT_CODE : WAKE_CODE;
                OFF_DIV: r.data = {20'($urandom()), DIV_PASS + 12'($urandom_range(40))};
                OFF_PHASE: r.data = {20'($urandom()), PHASE_PASS, 4'($urandom())};
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic queue_req(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
        t_osc_req r;
        r.op   = op;
        r.addr = addr;
        r.data = data;
        req_backlog.push_back(r);
    endtask

    // Seed write over the APB port: setup cycle, then access cycle.
    task automatic write_seed(input logic [63:0] seed);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= seed;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rng_state = (seed == 64'd0) ? GOLDEN : seed;
    endtask

    // Wait until every request has gone through and every response has come back.
    task automatic drain();
        @(negedge i_clk);
        while (req_backlog.size() != 0 || req_ch.valid || pending_rsps.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        @(negedge i_clk);
        for (int i = 0; i < n; i++) req_backlog.push_back(random_req());
        drain();
    endtask

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Length of the one long receiver hold-off, counted once it is armed.
    always @(posedge i_clk) begin
        if (long_hold_armed && long_hold_count < LONG_HOLD) begin
            long_hold_count <= long_hold_count + 1;
        end
    end

    // Request driver: predicts each accepted request, then offers the next one.
    always @(posedge i_clk) begin
        t_osc_req cur;
        t_osc_req nxt;
        t_osc_rsp predicted;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                cur.op   = req_ch.opcode;
                cur.addr = req_ch.address;
                cur.data = req_ch.write_data;
                reg_block_step(cur, predicted);
                pending_rsps.push_back(predicted);
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
                    nxt = req_backlog.pop_front();
                    req_ch.opcode     <= nxt.op;
                    req_ch.address    <= nxt.addr;
                    req_ch.write_data <= nxt.data;
                    req_ch.valid      <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: checks each response against the oldest prediction.
    always @(posedge i_clk) begin
        t_osc_rsp want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_rsps.size() == 0) begin
                    $error("response with no request outstanding: read_data %h clock_hz %0d",
                           rsp_ch.read_data, rsp_ch.clock_hz);
                    fail_count++;
                end else begin
                    want = pending_rsps.pop_front();
                    if (rsp_ch.read_data !== want.rd) begin
                        $error("read_data: expected %h, got %h", want.rd, rsp_ch.read_data);
                        fail_count++;
                    end
                    if (rsp_ch.clock_hz !== want.hz) begin
                        $error("clock_hz: expected %0d, got %0d", want.hz, rsp_ch.clock_hz);
                        fail_count++;
                    end
                end
            end
            // One long hold-off lets the block fill up and stall its input.
            if (long_hold_armed && long_hold_count < LONG_HOLD) begin
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        req_ch.valid      = 1'b0;
        req_ch.opcode     = '0;
        req_ch.address    = '0;
        req_ch.write_data = '0;
        rsp_ch.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        reset_regs();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests, starting from the reset values.
        @(negedge i_clk);
        for (int i = 0; i < 9; i++) queue_req(OP_READ, ADDR_W'(i * 4), '0);
        queue_req(OP_TICK, '0, '0);                              // tick at count zero
        queue_req(OP_READ, {AL_XOR, OFF_DIV}, 32'hffffffff);     // alias on a read
        queue_req(OP_READ, 14'h0013, '0);                        // unaligned offset
        queue_req(2'd3, 14'h3fff, 32'hffffffff);                 // unused opcode
        queue_req(OP_WRITE, {AL_NORMAL, OFF_CTRL}, 32'hff123000); // bad enable and range
        queue_req(OP_WRITE, {AL_NORMAL, OFF_STATUS}, 32'h01000000);
        queue_req(OP_WRITE, {AL_NORMAL, OFF_DIV}, {20'h0, DIV_PASS});        // divisor 32
        queue_req(OP_WRITE, {AL_NORMAL, OFF_DIV}, {20'h0, DIV_PASS + 12'd1}); // divisor 1
        queue_req(OP_WRITE, {AL_CLR, OFF_DIV}, 32'h00000fff);    // falls below the password
        queue_req(OP_WRITE, {AL_NORMAL, OFF_COUNT}, 32'hffffffff);
        queue_req(OP_TICK, '0, '0);
        queue_req(OP_WRITE, {AL_NORMAL, OFF_DORMANT}, DORMANT_CODE);
        queue_req(OP_READ, {AL_NORMAL, OFF_RANDOM}, '0);         // random bit while dormant
        queue_req(OP_WRITE, {AL_XOR, OFF_DORMANT}, '0);          // alias ignored, bad wake
        queue_req(OP_WRITE, {AL_SET, OFF_FREQA}, {FREQ_PASS, 16'hffff});
        queue_req(OP_WRITE, {AL_NORMAL, OFF_FREQB}, 32'h12345678);
        queue_req(OP_WRITE, {AL_CLR, OFF_PHASE}, 32'hffffffff);
        queue_req(OP_WRITE, {AL_NORMAL, OFF_CTRL}, {8'h00, EN_DISABLE, RANGE_HIGH});
        queue_req(OP_READ, {AL_NORMAL, OFF_RANDOM}, '0);         // random bit while disabled
        queue_req(OP_WRITE, {AL_NORMAL, OFF_CTRL}, {8'hff, EN_ENABLE, RANGE_LOW});
        queue_req(OP_READ, {AL_NORMAL, OFF_RANDOM}, '0);
        queue_req(OP_WRITE, 14'h3ffc, 32'hffffffff);             // write to an unknown offset
        queue_req(OP_READ, {AL_NORMAL, OFF_STATUS}, '0);
        drain();

        // Sender idles rarely, receiver often, with one long hold-off.
        write_seed(64'hffffffffffffffff);
        @(negedge i_clk);
        req_idle_pct    = 13;
        rsp_idle_pct    = 65;
        long_hold_armed = 1'b1;
        run_random(RANDOM_PER_PASS);

        // Sender idles often, receiver rarely.
        write_seed({$urandom(), $urandom()});
        @(negedge i_clk);
        req_idle_pct = 65;
        rsp_idle_pct = 13;
        run_random(RANDOM_PER_PASS);

        // Back to back with a zero seed.
        write_seed(64'd0);
        @(negedge i_clk);
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        run_random(RANDOM_PER_PASS);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/roc_pkg.sv
rtl/roc_if.sv
rtl/ring_oscillator_control_registers_top.sv
test/testbench.sv
